>>> rtl/lz78_pair_decoder_core_defines.svh
// Assertion macros for the LZ78 pair decoder.
// Included by the top level; define NO_ASSERTIONS to compile them away.
`ifndef LZ78_PAIR_DECODER_CORE_DEFINES_SVH
`define LZ78_PAIR_DECODER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// cond must never hold outside reset
`define LZ_ASSERT_NEVER(label, ck, rs, cond) \
    label: assert property (@(posedge ck) disable iff (!rs) !(cond)) \
        else $error("forbidden condition seen");
// ante implies cons in the same cycle
`define LZ_ASSERT_IMPL(label, ck, rs, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
        else $error("implication failed");
// ante implies cons in the next cycle
`define LZ_ASSERT_NEXT(label, ck, rs, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define LZ_ASSERT_NEVER(label, ck, rs, cond)
`define LZ_ASSERT_IMPL(label, ck, rs, ante, cons)
`define LZ_ASSERT_NEXT(label, ck, rs, ante, cons)
`endif
`endif

>>> rtl/lz78d_pkg.sv
// Shared types and constants of the LZ78 pair decoder.
// No dependencies.
`default_nettype none

package lz78d_pkg;

    localparam int IDX_W            = 16;
    localparam int BYTE_W           = 8;
    localparam int LEN_W            = 7;
    localparam int CNT_W            = IDX_W + 1;
    localparam int DICT_ENTRIES_DEF = 65536;
    localparam int MAX_LEN_DEF      = 64;
    localparam int Q_DEPTH          = 2;

    typedef struct packed {
        logic [IDX_W-1:0]  phrase_index;
        logic [BYTE_W-1:0] next_byte;
    } pair_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_phrase;
        logic              bad_index;
    } sym_t;

    // one classified pair, front to back
    typedef struct packed {
        logic              err;
        logic              wr;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  waddr;
        logic [LEN_W-1:0]  plen;
        logic [BYTE_W-1:0] nb;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             halted;
    } f_stat_t;

endpackage

`default_nettype wire

>>> rtl/lz78_pair_decoder_core.sv
// Top level of the LZ78 pair decoder: front, command queue, back.
// Uses lz78d_pkg, lz78d_front, lz78d_queue, lz78d_back and the defines header.
//
//   channel  beat     handshake              payload
//   pair     input    pair_valid/pair_stall  phrase_index[15:0], next_byte[7:0]
//   sym      output   sym_valid/sym_stall    out_byte[7:0], last_of_phrase, bad_index
//
// A pair of phrase length L passes the front states F_IDLE and F_CLASS,
// then one pop, L walk steps (one parent link per dictionary RAM read, the
// address of each read being the previous read's data), and L+1 emit beats
// plus one reverse-buffer read. Pairs too long to decode are dropped in the front.
// Reset is asynchronous, active low; the dictionary needs no clearing pass.
// sym_stall holds the output register; the back end then waits and the queue
// fills. pair_stall is high in the cycle after each accepted pair and stays
// high while the queue is full.
`default_nettype none
`include "lz78_pair_decoder_core_defines.svh"

module lz78_pair_decoder_core #(
    parameter int DICT_ENTRIES = lz78d_pkg::DICT_ENTRIES_DEF,
    parameter int MAX_LEN      = lz78d_pkg::MAX_LEN_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pair_valid,
    output logic             pair_stall,
    input  lz78d_pkg::pair_t pair,
    output logic             sym_valid,
    input  logic             sym_stall,
    output lz78d_pkg::sym_t  sym
);
    import lz78d_pkg::*;

    logic    push;
    logic    pop;
    cmd_t    push_cmd;
    cmd_t    head_cmd;
    q_stat_t q_stat;
    f_stat_t f_stat;

    // classification: index check, halt, length lookup, entry allocation
    lz78d_front #(
        .DICT_ENTRIES (DICT_ENTRIES),
        .MAX_LEN      (MAX_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .pair       (pair),
        .q_stat     (q_stat),
        .push       (push),
        .cmd        (push_cmd),
        .f_stat     (f_stat)
    );

    lz78d_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_cmd),
        .pop   (pop),
        .rdata (head_cmd),
        .stat  (q_stat)
    );

    // chain walk and byte emission
    lz78d_back #(
        .DICT_ENTRIES (DICT_ENTRIES),
        .MAX_LEN      (MAX_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head      (head_cmd),
        .pop       (pop),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .sym       (sym)
    );

    // entry count stays within 1..DICT_ENTRIES
    `LZ_ASSERT_NEVER(a_count_range, clk, rst_n, (f_stat.count == '0) || (f_stat.count > CNT_W'(DICT_ENTRIES)))
    // halt is sticky
    `LZ_ASSERT_NEXT(a_halt_sticky, clk, rst_n, f_stat.halted, f_stat.halted)
    // an error beat only leaves after the front has halted
    `LZ_ASSERT_IMPL(a_err_halted, clk, rst_n, sym_valid && sym.bad_index, f_stat.halted)
    // front never pushes into a full queue
    `LZ_ASSERT_NEVER(a_q_overflow, clk, rst_n, push && q_stat.full)

endmodule

`default_nettype wire

>>> rtl/lz78d_front.sv
// Front end: accepts pairs, checks the index, looks up phrase length.
// Owns entry count, halt flag and the length store. Uses lz78d_pkg.
`default_nettype none

module lz78d_front #(
    parameter int DICT_ENTRIES = lz78d_pkg::DICT_ENTRIES_DEF,
    parameter int MAX_LEN      = lz78d_pkg::MAX_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pair_valid,
    output logic              pair_stall,
    input  lz78d_pkg::pair_t  pair,
    input  lz78d_pkg::q_stat_t q_stat,
    output logic              push,
    output lz78d_pkg::cmd_t   cmd,
    output lz78d_pkg::f_stat_t f_stat
);
    import lz78d_pkg::*;

    localparam int AW = $clog2(DICT_ENTRIES);
    localparam int CW = $clog2(DICT_ENTRIES + 1);

    localparam logic [0:0] F_IDLE  = 1'b0;
    localparam logic [0:0] F_CLASS = 1'b1;

    logic [0:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              halted_reg, halted_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [BYTE_W-1:0] nb_reg;
    logic [LEN_W-1:0]  len_q;
    logic [LEN_W-1:0]  len_mem [DICT_ENTRIES];

    logic              accept;
    logic              err;
    logic              too_long;
    logic              room;
    logic              wr;
    logic [LEN_W-1:0]  plen;

    assign pair_stall = (state_reg != F_IDLE);
    assign accept     = pair_valid && !pair_stall;
    assign err        = halted_reg || (CNT_W'(idx_reg) >= CNT_W'(count_reg));
    assign plen       = (idx_reg == '0) ? '0 : len_q;
    assign too_long   = (plen >= LEN_W'(MAX_LEN));
    assign room       = (count_reg < CW'(DICT_ENTRIES));
    assign wr         = !err && room;
    assign push       = (state_reg == F_CLASS) && (err || !too_long) && !q_stat.full;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg <= pair.phrase_index;
            nb_reg  <= pair.next_byte;
            len_q   <= len_mem[pair.phrase_index[AW-1:0]];
        end
        if (push && wr)
        begin
            len_mem[count_reg[AW-1:0]] <= plen + LEN_W'(1);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        halted_next = halted_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_CLASS;
                end
            end
            F_CLASS:
            begin
                if (!err && too_long)
                begin
                    // dropped silently
                    state_next = F_IDLE;
                end
                else if (push)
                begin
                    state_next = F_IDLE;
                    if (err)
                    begin
                        halted_next = 1'b1;
                    end
                    else if (room)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            count_reg  <= CW'(1);
            halted_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
        end
    end

    assign cmd.err   = err;
    assign cmd.wr    = wr;
    assign cmd.idx   = idx_reg;
    assign cmd.waddr = IDX_W'(count_reg);
    assign cmd.plen  = err ? '0 : plen;
    assign cmd.nb    = nb_reg;

    assign f_stat.count  = CNT_W'(count_reg);
    assign f_stat.halted = halted_reg;

endmodule

`default_nettype wire

>>> rtl/lz78d_queue.sv
// Short command queue between front and back.
// Uses lz78d_pkg.
`default_nettype none

module lz78d_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lz78d_pkg::cmd_t    wdata,
    input  logic               pop,
    output lz78d_pkg::cmd_t    rdata,
    output lz78d_pkg::q_stat_t stat
);
    import lz78d_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    cmd_t          slot_mem [Q_DEPTH];
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [PW:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wp_reg] <= wdata;
        end
    end

    always_comb
    begin
        wp_next  = push ? wp_reg + PW'(1) : wp_reg;
        rp_next  = pop ? rp_reg + PW'(1) : rp_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + (PW+1)'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    assign rdata      = slot_mem[rp_reg];
    assign stat.full  = (cnt_reg == (PW+1)'(Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

`default_nettype wire

>>> rtl/lz78d_back.sv
// Back end: stores new entries, walks the parent chain, emits bytes.
// Holds the parent/last-byte stores and the reverse buffer. Uses lz78d_pkg.
`default_nettype none

module lz78d_back #(
    parameter int DICT_ENTRIES = lz78d_pkg::DICT_ENTRIES_DEF,
    parameter int MAX_LEN      = lz78d_pkg::MAX_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lz78d_pkg::q_stat_t q_stat,
    input  lz78d_pkg::cmd_t    head,
    output logic               pop,
    output logic               sym_valid,
    input  logic               sym_stall,
    output lz78d_pkg::sym_t    sym
);
    import lz78d_pkg::*;

    localparam int AW = $clog2(DICT_ENTRIES);
    localparam int BW = $clog2(MAX_LEN);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_WALK = 2'd1;
    localparam logic [1:0] B_EMIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    cmd_t              cmd_reg;
    logic [LEN_W-1:0]  k_reg, k_next;
    logic [LEN_W-1:0]  j_reg, j_next;
    logic              issued_reg, issued_next;
    logic              rv_reg, rv_next;
    logic              rfin_reg, rfin_next;
    logic              sv_reg, sv_next;
    sym_t              sym_reg;

    logic [IDX_W-1:0]  par_mem [DICT_ENTRIES];
    logic [BYTE_W-1:0] lb_mem  [DICT_ENTRIES];
    logic [BYTE_W-1:0] rbuf    [MAX_LEN];
    logic [IDX_W-1:0]  par_q;
    logic [BYTE_W-1:0] lb_q;
    logic [BYTE_W-1:0] rb_q;

    logic              rd_en;
    logic [AW-1:0]     raddr;
    logic [LEN_W-1:0]  k_dec;
    logic              out_free;
    logic              move;
    logic              issue;
    logic              issue_buf;

    assign pop       = (state_reg == B_IDLE) && !q_stat.empty;
    assign rd_en     = pop || (state_reg == B_WALK);
    assign raddr     = pop ? head.idx[AW-1:0] : par_q[AW-1:0];
    assign k_dec     = k_reg - LEN_W'(1);
    assign out_free  = !sv_reg || !sym_stall;
    assign move      = rv_reg && out_free;
    assign issue     = (state_reg == B_EMIT) && !issued_reg && (!rv_reg || move);
    assign issue_buf = issue && (j_reg < cmd_reg.plen);

    // dictionary: new entry written at pop, chain read one link a cycle
    always_ff @(posedge clk)
    begin
        if (pop && head.wr)
        begin
            par_mem[head.waddr[AW-1:0]] <= head.idx;
            lb_mem[head.waddr[AW-1:0]]  <= head.nb;
        end
        if (rd_en)
        begin
            par_q <= par_mem[raddr];
            lb_q  <= lb_mem[raddr];
        end
    end

    // reverse buffer: filled back to front, read front to back
    always_ff @(posedge clk)
    begin
        if (state_reg == B_WALK)
        begin
            rbuf[k_dec[BW-1:0]] <= lb_q;
        end
        if (issue_buf)
        begin
            rb_q <= rbuf[j_reg[BW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
        end
        if (move)
        begin
            sym_reg.out_byte       <= rfin_reg ? (cmd_reg.err ? '0 : cmd_reg.nb) : rb_q;
            sym_reg.last_of_phrase <= rfin_reg;
            sym_reg.bad_index      <= rfin_reg && cmd_reg.err;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        issued_next = issued_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    k_next      = head.plen;
                    j_next      = '0;
                    issued_next = 1'b0;
                    state_next  = (head.plen == '0) ? B_EMIT : B_WALK;
                end
            end
            B_WALK:
            begin
                k_next = k_dec;
                if (k_reg == LEN_W'(1))
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (issue)
                begin
                    if (issue_buf)
                    begin
                        j_next = j_reg + LEN_W'(1);
                    end
                    else
                    begin
                        issued_next = 1'b1;
                    end
                end
                if (move && rfin_reg)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rv_next   = rv_reg;
        rfin_next = rfin_reg;
        if (issue)
        begin
            rv_next   = 1'b1;
            rfin_next = !issue_buf;
        end
        else if (move)
        begin
            rv_next = 1'b0;
        end
        sv_next = move ? 1'b1 : (sym_stall ? sv_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            k_reg      <= '0;
            j_reg      <= '0;
            issued_reg <= 1'b0;
            rv_reg     <= 1'b0;
            rfin_reg   <= 1'b0;
            sv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            j_reg      <= j_next;
            issued_reg <= issued_next;
            rv_reg     <= rv_next;
            rfin_reg   <= rfin_next;
            sv_reg     <= sv_next;
        end
    end

    assign sym_valid = sv_reg;
    assign sym       = sym_reg;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for lz78_pair_decoder_core: directed head rows, random chains,
// then tail rows, scored by an in-bench dictionary predictor or a typed row's beat.
// Depends on lz78d_pkg and the lz78_pair_decoder_core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lz78d_pkg::*;

    // A 256-entry dictionary.
    localparam int DICT_N  = 256;
    localparam int MAX_LEN = MAX_LEN_DEF;

    localparam sym_t BAD_SYM = '{out_byte: 8'h00, last_of_phrase: 1'b1, bad_index: 1'b1};
    localparam sym_t NO_SYM  = '0;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

    // One stimulus row; typed rows carry their single expected beat.
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] nb;
        logic              typed;
        sym_t              want;
    } stim_row_t;

    localparam int N_HEAD = 15;
    localparam int N_TAIL = 6;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  pair_valid = 1'b0;
    logic  pair_stall;
    pair_t pair = '0;
    logic  sym_valid;
    logic  sym_stall = 1'b0;
    sym_t  sym;

    // Head rows build short chains from an empty dictionary; tail rows run last:
    // index 0x0100 is past any entry a 256-entry dictionary can hold, so it
    // halts the block, and every later row must see the sticky error.
    stim_row_t stim_rows [N_HEAD + N_TAIL] = '{
        '{16'd0,      8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}},  // empty phrase, zero byte
        '{16'd0,      8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b0}},  // empty phrase, all-ones byte
        '{16'd1,      8'h5A, 1'b0, NO_SYM},
        '{16'd2,      8'hA5, 1'b0, NO_SYM},
        '{16'd3,      8'h01, 1'b0, NO_SYM},
        '{16'd5,      8'h80, 1'b0, NO_SYM},
        '{16'd6,      8'h3C, 1'b0, NO_SYM},
        '{16'd0,      8'h7F, 1'b1, '{8'h7F, 1'b1, 1'b0}},
        '{16'd7,      8'hC3, 1'b0, NO_SYM},
        '{16'd9,      8'h00, 1'b0, NO_SYM},
        '{16'd10,     8'hFF, 1'b0, NO_SYM},
        '{16'd4,      8'h24, 1'b0, NO_SYM},
        '{16'd12,     8'h81, 1'b0, NO_SYM},                // newest entry
        '{16'd13,     8'h42, 1'b0, NO_SYM},                // newest entry again
        '{16'd1,      8'hFE, 1'b0, NO_SYM},
        '{16'h0100,   8'h12, 1'b1, BAD_SYM},               // past the last possible entry
        '{16'hFFFF,   8'hFF, 1'b1, BAD_SYM},
        '{16'h0000,   8'h00, 1'b1, BAD_SYM},               // valid index, but halted
        '{16'h5555,   8'hAA, 1'b1, BAD_SYM},
        '{16'hAAAA,   8'h55, 1'b1, BAD_SYM},
        '{16'h0001,   8'h7E, 1'b1, BAD_SYM}
    };

    // Predictor state: mirror of the decoder dictionary.
    logic [IDX_W-1:0]  dict_parent [DICT_N];
    logic [BYTE_W-1:0] dict_byte   [DICT_N];
    logic [LEN_W-1:0]  dict_len    [DICT_N];
    int                dict_count = 1;
    logic              decoder_halted = 1'b0;
    logic [IDX_W-1:0]  longest_idx = '0;
    int                longest_len = 0;
    logic              too_long_seen = 1'b0;

    sym_t phrase_syms [$];      // beats of the pair just decoded
    sym_t expected_syms [$];    // beats still owed by the block
    int   fail_count = 0;
    int   burst_left = 0;

    rx_mode_e rx_mode = RX_FREE;
    int       rx_left = 0;

    lz78_pair_decoder_core #(
        .DICT_ENTRIES(DICT_N),
        .MAX_LEN     (MAX_LEN)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair_valid(pair_valid),
        .pair_stall(pair_stall),
        .pair      (pair),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .sym       (sym)
    );

    always #5 clk = ~clk;

    // Decode one pair against the mirrored dictionary; fills phrase_syms and
    // returns the beat count (zero for a phrase too long to emit).
    function automatic int decode_pair(input pair_t p);
        logic [BYTE_W-1:0] rev [MAX_LEN];
        int plen;
        int cur;
        phrase_syms.delete();
        if (decoder_halted || p.phrase_index >= dict_count) begin
            decoder_halted = 1'b1;
            phrase_syms.push_back(BAD_SYM);
            return 1;
        end
        plen = (p.phrase_index == 0) ? 0 : int'(dict_len[p.phrase_index]);
        if (plen + 1 > MAX_LEN) begin
            too_long_seen = 1'b1;
            return 0;
        end
        // walk the parent links back to the root, filling from the tail
        cur = p.phrase_index;
        for (int k = plen; k > 0; k--) begin
            rev[k-1] = dict_byte[cur];
            cur = dict_parent[cur];
        end
        for (int k = 0; k < plen; k++)
            phrase_syms.push_back(sym_t'{rev[k], 1'b0, 1'b0});
        phrase_syms.push_back(sym_t'{p.next_byte, 1'b1, 1'b0});
        if (dict_count < DICT_N) begin
            dict_parent[dict_count] = p.phrase_index;
            dict_byte[dict_count]   = p.next_byte;
            dict_len[dict_count]    = LEN_W'(plen + 1);
            if (plen + 1 > longest_len) begin
                longest_idx = IDX_W'(dict_count);
                longest_len = plen + 1;
            end
            dict_count++;
        end
        return plen + 1;
    endfunction

    // Nearly half the time extend the longest chain so phrases reach MAX_LEN; the rest
    // spreads over the newest, the empty and any valid entry.
    function automatic logic [IDX_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return longest_idx;
        if (r < 65)
            return IDX_W'(dict_count - 1);
        if (r < 75)
            return '0;
        return IDX_W'($urandom_range(0, dict_count - 1));
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic push_pair(input pair_t p, input logic typed, input sym_t want,
                             output int n_res);
        pair       <= p;
        pair_valid <= 1'b1;
        @(posedge clk);
        while (pair_stall)
            @(posedge clk);
        n_res = decode_pair(p);
        if (typed)
            expected_syms.push_back(want);
        else
            foreach (phrase_syms[i])
                expected_syms.push_back(phrase_syms[i]);
        @(negedge clk);
    endtask

    // Sender bursts: random run lengths with random idle gaps between them.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 15);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
            pair_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Hold the sender off until every owed beat has come out.
    task automatic drain_block();
        pair_valid <= 1'b0;
        @(posedge clk);
        while (expected_syms.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic walk_rows(input int first, input int last_row);
        int n_res;
        pair_t p;
        for (int i = first; i <= last_row; i++) begin
            p.phrase_index = stim_rows[i].idx;
            p.next_byte    = stim_rows[i].nb;
            push_pair(p, stim_rows[i].typed, stim_rows[i].want, n_res);
            pace_sender();
        end
    endtask

    // Receiver: stall pattern switches mode after a random run.
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_e'($urandom_range(0, 3));
            rx_left <= $urandom_range(8, 60);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:  sym_stall <= 1'b0;
            RX_LIGHT: sym_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: sym_stall <= ($urandom_range(0, 3) != 0);
            default:  sym_stall <= ~sym_stall;
        endcase
    end

    // Score every output beat against the oldest owed beat.
    always @(posedge clk) begin
        sym_t want;
        if (rst_n && sym_valid && !sym_stall) begin
            if (expected_syms.size() == 0) begin
                $error("unexpected beat: out_byte %0h last_of_phrase %0b bad_index %0b",
                       sym.out_byte, sym.last_of_phrase, sym.bad_index);
                fail_count++;
            end else begin
                want = expected_syms.pop_front();
                if (sym.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, sym.out_byte);
                    fail_count++;
                end
                if (sym.last_of_phrase !== want.last_of_phrase) begin
                    $error("last_of_phrase: expected %0b, got %0b",
                           want.last_of_phrase, sym.last_of_phrase);
                    fail_count++;
                end
                if (sym.bad_index !== want.bad_index) begin
                    $error("bad_index: expected %0b, got %0b", want.bad_index, sym.bad_index);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int n_res;
        int served;
        pair_t p;
        served = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        walk_rows(0, N_HEAD - 1);
        drain_block();

        // Random chains. No malformed traffic exists short of a bad index,
        // which halts the block for good, so that is saved for the tail.
        // Keep going until 100 pairs are served and a too-long phrase has been seen.
        while (served < 100 || !too_long_seen) begin
            p.phrase_index = pick_index();
            p.next_byte    = BYTE_W'($urandom_range(0, 255));
            push_pair(p, 1'b0, NO_SYM, n_res);
            if (n_res > 0)
                served++;
            if (served % 50 == 49 && n_res > 0)
                drain_block();
            else
                pace_sender();
        end
        drain_block();

        walk_rows(N_HEAD, N_HEAD + N_TAIL - 1);
        pair_valid <= 1'b0;

        while (expected_syms.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("lz78_pair_decoder_core test passed");
        else
            $display("lz78_pair_decoder_core test failed");
        $finish;
    end

    // Hang guard, well past the slowest legal run.
    initial begin
        #10_000_000;
        $display("lz78_pair_decoder_core test failed");
        $finish;
    end

endmodule
